// File: rtl/tile_map_primitive_drawer_defines.svh
// assertion macros for the tile map drawer
// expects clk and arst_n in the scope of each use
`ifndef TILE_MAP_PRIMITIVE_DRAWER_DEFINES_SVH
`define TILE_MAP_PRIMITIVE_DRAWER_DEFINES_SVH

// same-cycle implication
`define TMPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tmpd_pkg.sv
// shared types, codes and defaults of the tile map drawer
// no dependencies
`default_nettype none

package tmpd_pkg;

	localparam int MAP_WIDTH_DEF  = 64;
	localparam int MAP_HEIGHT_DEF = 32;
	localparam int TILE_BITS_DEF  = 4;

	localparam logic [2:0] MODE_READ    = 3'd0;
	localparam logic [2:0] MODE_FILL    = 3'd1;
	localparam logic [2:0] MODE_OUTLINE = 3'd2;
	localparam logic [2:0] MODE_HLINE   = 3'd3;
	localparam logic [2:0] MODE_VLINE   = 3'd4;
	localparam logic [2:0] MODE_HELBOW  = 3'd5;
	localparam logic [2:0] MODE_VELBOW  = 3'd6;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_READ,
		ST_FIN
	} state_t;

	// one span: the fixed coordinate and two unordered end points
	typedef struct packed {
		logic       axis;
		logic [7:0] fixed;
		logic [7:0] a;
		logic [7:0] b;
	} seg_desc_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] x;
		logic [7:0] y;
		logic       on_map;
		logic       last;
	} step_t;

	typedef struct packed {
		logic       we;
		logic       re;
		logic [7:0] x;
		logic [7:0] y;
	} mem_req_t;

	typedef struct packed {
		logic fin;
		logic clip;
		logic show_read;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/tmpd_store.sv
// tile store: one address per cycle, registered read data
// depends on tmpd_pkg
`default_nettype none

module tmpd_store #(
	parameter int MAP_WIDTH  = tmpd_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = tmpd_pkg::MAP_HEIGHT_DEF,
	parameter int TILE_BITS  = tmpd_pkg::TILE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire tmpd_pkg::mem_req_t   req,
	input  wire logic [TILE_BITS-1:0] wdata,
	output logic      [TILE_BITS-1:0] rdata
);
	import tmpd_pkg::*;

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [TILE_BITS-1:0] mem [DEPTH];
	logic [15:0]          addr_full;
	logic [AW-1:0]        addr;

	// row major address, only used for tiles inside the map
	assign addr_full = 16'(req.y) * 16'(MAP_WIDTH) + 16'(req.x);
	assign addr      = addr_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= wdata;
		end
		if (req.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tmpd_walk.sv
// span walker: steps one tile a cycle from the low to the high end point
// depends on tmpd_pkg
`default_nettype none

module tmpd_walk #(
	parameter int MAP_WIDTH  = tmpd_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = tmpd_pkg::MAP_HEIGHT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire tmpd_pkg::seg_desc_t desc,
	output tmpd_pkg::step_t          step
);
	import tmpd_pkg::*;

	localparam logic [8:0] W9 = 9'(MAP_WIDTH);
	localparam logic [8:0] H9 = 9'(MAP_HEIGHT);

	logic       active_q;
	logic       axis_q;
	logic [7:0] fixed_q;
	logic [7:0] cur_q;
	logic [7:0] hi_q;
	logic       a_le_b;
	logic [7:0] x;
	logic [7:0] y;

	assign a_le_b = desc.a <= desc.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (active_q && cur_q == hi_q) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			axis_q  <= desc.axis;
			fixed_q <= desc.fixed;
			cur_q   <= a_le_b ? desc.a : desc.b;
			hi_q    <= a_le_b ? desc.b : desc.a;
		end else if (active_q && cur_q != hi_q) begin
			cur_q <= cur_q + 8'd1;
		end
	end

	always_comb begin
		x = (axis_q == AXIS_X) ? cur_q : fixed_q;
		y = (axis_q == AXIS_X) ? fixed_q : cur_q;
		step.valid  = active_q;
		step.x      = x;
		step.y      = y;
		step.on_map = ({1'b0, x} < W9) && ({1'b0, y} < H9);
		step.last   = cur_q == hi_q;
	end

endmodule

`default_nettype wire

// File: rtl/tmpd_ctrl.sv
// command sequencer: splits a command into spans for the walker,
// issues reads and collects the clip flag; depends on tmpd_pkg
`default_nettype none

module tmpd_ctrl #(
	parameter int MAP_WIDTH  = tmpd_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = tmpd_pkg::MAP_HEIGHT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [2:0]          mode,
	input  wire logic [7:0]          x_start,
	input  wire logic [7:0]          y_start,
	input  wire logic [7:0]          x_end,
	input  wire logic [7:0]          y_end,
	input  wire tmpd_pkg::step_t     step,
	output logic                     busy,
	output logic                     load,
	output tmpd_pkg::seg_desc_t      desc,
	output tmpd_pkg::mem_req_t       req,
	output tmpd_pkg::res_t           res
);
	import tmpd_pkg::*;

	`include "tile_map_primitive_drawer_defines.svh"

	localparam logic [8:0] W9 = 9'(MAP_WIDTH);
	localparam logic [8:0] H9 = 9'(MAP_HEIGHT);

	state_t     state_q, state_d;
	logic [2:0] mode_q;
	logic [7:0] xa_q, ya_q, xb_q, yb_q, mid_q;
	logic [1:0] seg_q;
	logic [7:0] row_q;
	logic       clip_q;
	logic       read_ok_q;

	logic       accept;
	logic       swap;
	logic [7:0] x1, y1, x2, y2;
	logic [8:0] mid_sum;
	logic       rect_ok;
	logic       rd_inside;
	logic [1:0] last_seg;
	logic       span_end;

	assign accept = start && (state_q == ST_IDLE);

	// elbows are swapped as whole points
	always_comb begin
		swap = ((mode == MODE_HELBOW) && (x_start > x_end)) ||
		       ((mode == MODE_VELBOW) && (y_start > y_end));
		x1 = swap ? x_end : x_start;
		y1 = swap ? y_end : y_start;
		x2 = swap ? x_start : x_end;
		y2 = swap ? y_start : y_end;
		mid_sum = (mode == MODE_VELBOW) ? (9'(y1) + 9'(y2)) : (9'(x1) + 9'(x2));
		rect_ok = (x_start <= x_end) && (y_start <= y_end);
		rd_inside = ({1'b0, x_start} < W9) && ({1'b0, y_start} < H9);
	end

	always_comb begin
		case (mode_q)
			MODE_OUTLINE: last_seg = 2'd3;
			MODE_HELBOW,
			MODE_VELBOW:  last_seg = 2'd2;
			default:      last_seg = 2'd0;
		endcase
	end

	assign span_end = step.valid && step.last;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_READ:    state_d = ST_READ;
						MODE_FILL,
						MODE_OUTLINE: state_d = rect_ok ? ST_LOAD : ST_FIN;
						MODE_HLINE,
						MODE_VLINE,
						MODE_HELBOW,
						MODE_VELBOW:  state_d = ST_LOAD;
						default:      state_d = ST_FIN;
					endcase
				end
			end
			ST_LOAD: state_d = ST_WALK;
			ST_WALK: begin
				if (span_end) begin
					if (mode_q == MODE_FILL) begin
						state_d = (row_q == yb_q) ? ST_FIN : ST_LOAD;
					end else begin
						state_d = (seg_q == last_seg) ? ST_FIN : ST_LOAD;
					end
				end
			end
			ST_READ: state_d = ST_FIN;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = state_q != ST_IDLE;
		load = state_q == ST_LOAD;

		desc = '{axis: AXIS_X, fixed: ya_q, a: xa_q, b: xb_q};
		case (mode_q)
			MODE_FILL: desc = '{axis: AXIS_X, fixed: row_q, a: xa_q, b: xb_q};
			MODE_OUTLINE: begin
				case (seg_q)
					2'd0:    desc = '{axis: AXIS_X, fixed: ya_q, a: xa_q, b: xb_q};
					2'd1:    desc = '{axis: AXIS_X, fixed: yb_q, a: xa_q, b: xb_q};
					2'd2:    desc = '{axis: AXIS_Y, fixed: xa_q, a: ya_q, b: yb_q};
					default: desc = '{axis: AXIS_Y, fixed: xb_q, a: ya_q, b: yb_q};
				endcase
			end
			MODE_HLINE: desc = '{axis: AXIS_X, fixed: ya_q, a: xa_q, b: xb_q};
			MODE_VLINE: desc = '{axis: AXIS_Y, fixed: xa_q, a: ya_q, b: yb_q};
			MODE_HELBOW: begin
				case (seg_q)
					2'd0:    desc = '{axis: AXIS_X, fixed: ya_q, a: xa_q, b: mid_q};
					2'd1:    desc = '{axis: AXIS_Y, fixed: mid_q, a: ya_q, b: yb_q};
					default: desc = '{axis: AXIS_X, fixed: yb_q, a: mid_q, b: xb_q};
				endcase
			end
			MODE_VELBOW: begin
				case (seg_q)
					2'd0:    desc = '{axis: AXIS_Y, fixed: xa_q, a: ya_q, b: mid_q};
					2'd1:    desc = '{axis: AXIS_X, fixed: mid_q, a: xa_q, b: xb_q};
					default: desc = '{axis: AXIS_Y, fixed: xb_q, a: mid_q, b: yb_q};
				endcase
			end
			default: desc = '{axis: AXIS_X, fixed: ya_q, a: xa_q, b: xb_q};
		endcase

		req.re = (state_q == ST_READ) && read_ok_q;
		req.we = step.valid && step.on_map;
		req.x  = (state_q == ST_READ) ? xa_q : step.x;
		req.y  = (state_q == ST_READ) ? ya_q : step.y;

		res.fin       = state_q == ST_FIN;
		res.clip      = clip_q;
		res.show_read = read_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seg_q     <= 2'd0;
			row_q     <= 8'd0;
			clip_q    <= 1'b0;
			read_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				seg_q     <= 2'd0;
				row_q     <= y_start;
				clip_q    <= (mode == MODE_READ) && !rd_inside;
				read_ok_q <= (mode == MODE_READ) && rd_inside;
			end else if (state_q == ST_WALK) begin
				if (step.valid && !step.on_map) begin
					clip_q <= 1'b1;
				end
				if (span_end) begin
					seg_q <= seg_q + 2'd1;
					row_q <= row_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			xa_q   <= x1;
			ya_q   <= y1;
			xb_q   <= x2;
			yb_q   <= y2;
			mid_q  <= mid_sum[8:1];
		end
	end

	`TMPD_ASSERT_NXT(a_fin_single, res.fin, !res.fin, "result strobe longer than one cycle")
	`TMPD_ASSERT_IMP(a_step_in_walk, step.valid, state_q == ST_WALK, "walker runs outside walk state")
	`TMPD_ASSERT_NXT(a_read_then_fin, state_q == ST_READ, state_q == ST_FIN, "read not followed by result")
	`TMPD_ASSERT_NXT(a_load_starts, load, step.valid, "span load did not start the walker")

endmodule

`default_nettype wire

// File: rtl/tile_map_primitive_drawer.sv
// Tile map drawer. A command is taken when start is high and busy is low. A read
// goes from the read state, where the store is read, to the finish state and then
// to the done strobe; a draw loads each span (each row of a fill, each side of an
// outline, each leg of an elbow) into the single span walker, which steps one tile
// per cycle into the single-port tile store and visits every tile the span
// addresses, clipped tiles and tiles shared by two spans included, then finishes.
// A reversed rectangle or an unused mode goes straight to the finish state.
// Done is high for exactly one cycle with the result on read_tile and clipped;
// the receiver cannot stall, and busy falls while that word is shown. The store is
// not cleared at reset: read a tile only after it was drawn.
`default_nettype none

module tile_map_primitive_drawer #(
	parameter int MAP_WIDTH  = tmpd_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = tmpd_pkg::MAP_HEIGHT_DEF,
	parameter int TILE_BITS  = tmpd_pkg::TILE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] x_start,
	input  wire logic [7:0] y_start,
	input  wire logic [7:0] x_end,
	input  wire logic [7:0] y_end,
	input  wire logic [3:0] tile,
	output logic            done,
	output logic [3:0]      read_tile,
	output logic            clipped
);
	import tmpd_pkg::*;

	logic                 accept;
	logic                 load;
	seg_desc_t            desc;
	step_t                step;
	mem_req_t             req;
	res_t                 res;
	logic [TILE_BITS-1:0] code_q;
	logic [TILE_BITS-1:0] rdata;
	logic [7:0]           tile_wide;
	logic [7:0]           rdata_wide;

	logic       done_q;
	logic       clipped_q;
	logic [3:0] read_tile_q;

	assign accept     = start && !busy;
	assign tile_wide  = 8'(tile);
	assign rdata_wide = 8'(rdata);

	tmpd_ctrl #(
		.MAP_WIDTH (MAP_WIDTH),
		.MAP_HEIGHT(MAP_HEIGHT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.x_start(x_start),
		.y_start(y_start),
		.x_end  (x_end),
		.y_end  (y_end),
		.step   (step),
		.busy   (busy),
		.load   (load),
		.desc   (desc),
		.req    (req),
		.res    (res)
	);

	tmpd_walk #(
		.MAP_WIDTH (MAP_WIDTH),
		.MAP_HEIGHT(MAP_HEIGHT)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.desc  (desc),
		.step  (step)
	);

	tmpd_store #(
		.MAP_WIDTH (MAP_WIDTH),
		.MAP_HEIGHT(MAP_HEIGHT),
		.TILE_BITS (TILE_BITS)
	) u_store (
		.clk  (clk),
		.req  (req),
		.wdata(code_q),
		.rdata(rdata)
	);

	// tile code masked to the stored width
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= tile_wide[TILE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fin) begin
			clipped_q   <= res.clip;
			read_tile_q <= res.show_read ? rdata_wide[3:0] : 4'd0;
		end
	end

	assign done      = done_q;
	assign clipped   = clipped_q;
	assign read_tile = read_tile_q;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// self-checking bench for the tile map primitive drawer: directed table, then random words
// depends on tmpd_pkg and tile_map_primitive_drawer
module tb;
	import tmpd_pkg::*;

	localparam int MAP_W = MAP_WIDTH_DEF;
	localparam int MAP_H = MAP_HEIGHT_DEF;
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int RANDOM_WORDS = 900;
	// a full 256 x 256 fill walks about 66k tiles with no handshake at all
	localparam int STALL_LIMIT = 300000;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		logic [3:0] rd;
		logic       clip;
	} tile_word_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] xs;
		logic [7:0] ys;
		logic [7:0] xe;
		logic [7:0] ye;
		logic [3:0] tl;
		logic       typed;
		logic [3:0] rd;
		logic       clip;
	} cmd_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] mode = '0;
	logic [7:0] x_start = '0;
	logic [7:0] y_start = '0;
	logic [7:0] x_end = '0;
	logic [7:0] y_end = '0;
	logic [3:0] tile = '0;
	logic       busy;
	logic       done;
	logic [3:0] read_tile;
	logic       clipped;

	// expectation typed into the directed table, carried along with the word
	logic       row_typed = 1'b0;
	logic [3:0] row_rd = '0;
	logic       row_clip = 1'b0;

	logic [3:0] tile_map [MAP_W*MAP_H];
	bit         off_map;
	tile_word_t expected_words [$];
	tile_word_t word_want;
	tile_word_t word_got;
	cmd_row_t   directed_rows [25];

	int words_taken = 0;
	int reads_taken = 0;
	int unused_taken = 0;
	int clipped_seen = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	tile_map_primitive_drawer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.tile     (tile),
		.done     (done),
		.read_tile(read_tile),
		.clipped  (clipped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void plot(input int x, input int y, input logic [3:0] code);
		if (x >= MAP_W || y >= MAP_H) begin
			off_map = 1'b1;
		end else begin
			tile_map[y*MAP_W + x] = code;
		end
	endfunction

	function automatic void run_x(input int a, input int b, input int y, input logic [3:0] code);
		int lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		for (int x = lo; x <= hi; x++)
			plot(x, y, code);
	endfunction

	function automatic void run_y(input int x, input int a, input int b, input logic [3:0] code);
		int lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		for (int y = lo; y <= hi; y++)
			plot(x, y, code);
	endfunction

	// applies one command to the local map and returns the word it should produce
	function automatic tile_word_t draw_cmd(input logic [2:0] m, input int xa, input int ya,
			input int xb, input int yb, input logic [3:0] code);
		tile_word_t w;
		int t, mid;
		w = '0;
		off_map = 1'b0;
		case (m)
			MODE_READ: begin
				if (xa >= MAP_W || ya >= MAP_H)
					off_map = 1'b1;
				else
					w.rd = tile_map[ya*MAP_W + xa];
			end
			MODE_FILL: begin
				if (xa <= xb && ya <= yb)
					for (int y = ya; y <= yb; y++)
						run_x(xa, xb, y, code);
			end
			MODE_OUTLINE: begin
				if (xa <= xb && ya <= yb) begin
					run_x(xa, xb, ya, code);
					run_x(xa, xb, yb, code);
					run_y(xa, ya, yb, code);
					run_y(xb, ya, yb, code);
				end
			end
			MODE_HLINE: begin
				run_x(xa, xb, ya, code);
			end
			MODE_VLINE: begin
				run_y(xa, ya, yb, code);
			end
			MODE_HELBOW: begin
				// whole points swap so the walk starts at the smaller x
				if (xa > xb) begin
					t = xa; xa = xb; xb = t;
					t = ya; ya = yb; yb = t;
				end
				mid = xa + (xb - xa) / 2;
				run_x(xa, mid, ya, code);
				run_y(mid, ya, yb, code);
				run_x(mid, xb, yb, code);
			end
			MODE_VELBOW: begin
				if (ya > yb) begin
					t = xa; xa = xb; xb = t;
					t = ya; ya = yb; yb = t;
				end
				mid = ya + (yb - ya) / 2;
				run_y(xa, ya, mid, code);
				run_x(xa, xb, mid, code);
				run_y(xb, mid, yb, code);
			end
			default: begin
			end
		endcase
		w.clip = off_map;
		return w;
	endfunction

	// mostly on or just past the map, sometimes anywhere, sometimes the extremes
	function automatic logic [7:0] pick_coord(input int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 8'($urandom_range(0, lim + 4));
		else if (r < 95)
			return 8'($urandom_range(0, 255));
		else
			return r[0] ? 8'd255 : 8'd0;
	endfunction

	function automatic logic [7:0] stretch(input logic [7:0] s);
		int e;
		e = int'(s) + $urandom_range(0, 12);
		return (e > 255) ? 8'd255 : 8'(e);
	endfunction

	function automatic cmd_row_t random_cmd();
		cmd_row_t c;
		int r;
		c = '0;
		c.typed = PREDICTED;
		c.tl = 4'($urandom_range(0, 15));
		c.xs = pick_coord(MAP_W - 1);
		c.ys = pick_coord(MAP_H - 1);
		c.xe = pick_coord(MAP_W - 1);
		c.ye = pick_coord(MAP_H - 1);
		r = $urandom_range(0, 99);
		if (r < 25) begin
			c.mode = MODE_READ;
			// the fields a read ignores still get random values
			c.xe = 8'($urandom_range(0, 255));
			c.ye = 8'($urandom_range(0, 255));
		end else if (r < 40) begin
			c.mode = MODE_FILL;
			// fills stay small to bound the run; a few come reversed
			c.xe = stretch(c.xs);
			c.ye = stretch(c.ys);
			if ($urandom_range(0, 9) == 0) begin
				if (c.xs != 0)
					c.xe = 8'($urandom_range(0, c.xs - 1));
				else if (c.ys != 0)
					c.ye = 8'($urandom_range(0, c.ys - 1));
			end
		end else if (r < 52) begin
			c.mode = MODE_OUTLINE;
			if (r[0]) begin
				c.xe = stretch(c.xs);
				c.ye = stretch(c.ys);
			end
		end else if (r < 64) begin
			c.mode = MODE_HLINE;
			c.ye = 8'($urandom_range(0, 255));
		end else if (r < 76) begin
			c.mode = MODE_VLINE;
			c.xe = 8'($urandom_range(0, 255));
		end else if (r < 87) begin
			c.mode = MODE_HELBOW;
		end else if (r < 97) begin
			c.mode = MODE_VELBOW;
		end else begin
			c.mode = MODE_UNUSED;
		end
		return c;
	endfunction

	// sends one word in bursts with random gaps, returns at the negedge after it is taken
	task automatic issue(input cmd_row_t c);
		int seen, gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start <= 1'b1;
		mode <= c.mode;
		x_start <= c.xs;
		y_start <= c.ys;
		x_end <= c.xe;
		y_end <= c.ye;
		tile <= c.tl;
		row_typed <= c.typed;
		row_rd <= c.rd;
		row_clip <= c.clip;
		seen = words_taken;
		do @(negedge clk); while (words_taken == seen);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with no command pending");
					fail_count++;
				end else begin
					word_want = expected_words.pop_front();
					if (read_tile !== word_want.rd) begin
						$error("read_tile: expected %0h, got %0h", word_want.rd, read_tile);
						fail_count++;
					end
					if (clipped !== word_want.clip) begin
						$error("clipped: expected %0b, got %0b", word_want.clip, clipped);
						fail_count++;
					end
				end
				if (clipped === 1'b1)
					clipped_seen++;
			end
			if (start && !busy) begin
				word_got = draw_cmd(mode, x_start, y_start, x_end, y_end, tile);
				if (row_typed)
					word_got = '{rd: row_rd, clip: row_clip};
				expected_words.push_back(word_got);
				words_taken++;
				if (mode == MODE_READ)
					reads_taken++;
				if (mode == MODE_UNUSED)
					unused_taken++;
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tile_map_primitive_drawer test failed");
				$finish;
			end
		end
	end

	initial begin
		// the full-range fill in the second row writes every map tile, so every
		// later read of an on-map tile sees a written entry
		directed_rows = '{
			'{MODE_READ,    8'd255, 8'd255, 8'd0,   8'd0,   4'h0, TYPED,     4'h0, 1'b1},
			'{MODE_FILL,    8'd0,   8'd0,   8'd255, 8'd255, 4'hf, TYPED,     4'h0, 1'b1},
			'{MODE_READ,    8'd0,   8'd0,   8'd0,   8'd0,   4'h0, TYPED,     4'hf, 1'b0},
			'{MODE_READ,    8'd63,  8'd31,  8'd255, 8'd255, 4'hf, TYPED,     4'hf, 1'b0},
			'{MODE_READ,    8'd64,  8'd0,   8'd0,   8'd0,   4'h0, TYPED,     4'h0, 1'b1},
			'{MODE_READ,    8'd0,   8'd32,  8'd0,   8'd0,   4'h0, TYPED,     4'h0, 1'b1},
			'{MODE_FILL,    8'd10,  8'd5,   8'd9,   8'd6,   4'h3, TYPED,     4'h0, 1'b0},
			'{MODE_OUTLINE, 8'd5,   8'd10,  8'd6,   8'd9,   4'h3, TYPED,     4'h0, 1'b0},
			'{MODE_FILL,    8'd2,   8'd3,   8'd5,   8'd4,   4'h0, TYPED,     4'h0, 1'b0},
			'{MODE_READ,    8'd3,   8'd3,   8'd0,   8'd0,   4'h0, TYPED,     4'h0, 1'b0},
			'{MODE_OUTLINE, 8'd1,   8'd1,   8'd62,  8'd30,  4'ha, TYPED,     4'h0, 1'b0},
			'{MODE_READ,    8'd62,  8'd15,  8'd0,   8'd0,   4'h0, TYPED,     4'ha, 1'b0},
			'{MODE_HLINE,   8'd60,  8'd2,   8'd3,   8'd0,   4'h5, PREDICTED, 4'h0, 1'b0},
			'{MODE_HLINE,   8'd0,   8'd31,  8'd255, 8'd0,   4'h6, TYPED,     4'h0, 1'b1},
			'{MODE_VLINE,   8'd63,  8'd255, 8'd0,   8'd0,   4'h4, TYPED,     4'h0, 1'b1},
			'{MODE_HLINE,   8'd200, 8'd0,   8'd255, 8'd0,   4'h8, TYPED,     4'h0, 1'b1},
			'{MODE_HELBOW,  8'd40,  8'd2,   8'd10,  8'd20,  4'h7, PREDICTED, 4'h0, 1'b0},
			'{MODE_HELBOW,  8'd0,   8'd0,   8'd255, 8'd255, 4'h9, TYPED,     4'h0, 1'b1},
			'{MODE_VELBOW,  8'd5,   8'd25,  8'd30,  8'd3,   4'hc, PREDICTED, 4'h0, 1'b0},
			'{MODE_VELBOW,  8'd255, 8'd0,   8'd0,   8'd255, 4'h1, TYPED,     4'h0, 1'b1},
			'{MODE_UNUSED,  8'd255, 8'd255, 8'd255, 8'd255, 4'hf, TYPED,     4'h0, 1'b0},
			'{MODE_READ,    8'd25,  8'd11,  8'd0,   8'd0,   4'h0, PREDICTED, 4'h0, 1'b0},
			'{MODE_READ,    8'd30,  8'd10,  8'd0,   8'd0,   4'h0, PREDICTED, 4'h0, 1'b0},
			'{MODE_OUTLINE, 8'd0,   8'd0,   8'd255, 8'd255, 4'h2, TYPED,     4'h0, 1'b1},
			'{MODE_READ,    8'd63,  8'd31,  8'd0,   8'd0,   4'h0, PREDICTED, 4'h0, 1'b0}
		};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[n])
			issue(directed_rows[n]);
		repeat (RANDOM_WORDS)
			issue(random_cmd());
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		$display("ran %0d commands: %0d reads, %0d in the unused mode, %0d draws",
			words_taken, reads_taken, unused_taken, words_taken - reads_taken - unused_taken);
		$display("%0d result words came back flagged clipped", clipped_seen);
		if (fail_count == 0)
			$display("tile_map_primitive_drawer test passed");
		else
			$display("tile_map_primitive_drawer test failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tmpd_pkg.sv
rtl/tmpd_store.sv
rtl/tmpd_walk.sv
rtl/tmpd_ctrl.sv
rtl/tile_map_primitive_drawer.sv
verif/tb.sv
